FILE: sv/abc_note_stream_parser_defines.svh
// Assertion macros shared by the ABC note stream parser.
`ifndef ABC_NOTE_STREAM_PARSER_DEFINES_SVH
`define ABC_NOTE_STREAM_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABCNSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABCNSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/abcnsp_pkg.sv
// Types, character codes and tables shared by the ABC note stream parser.
package abcnsp_pkg;

  typedef struct packed {
    logic       eot;
    logic       digit;
    logic [7:0] ch;
  } sym_t;

  typedef enum logic [4:0] {
    P_IDLE, P_QUOTE, P_PLUS, P_LINE, P_KEY, P_CHORD,
    P_HPRE, P_HNUM, P_HDEN, P_QEQ, P_QSP, P_QBPM,
    P_SHARP, P_FLAT, P_OCT_UP, P_OCT_DOWN, P_DMUL, P_DDIV, P_DOTS
  } mode_t;

  typedef enum logic [2:0] {
    SQ_PARSE, SQ_HMUL, SQ_HDIV, SQ_TDIV, SQ_RDIV
  } seq_t;

  typedef enum logic [1:0] {
    HK_M, HK_L, HK_Q
  } hkind_t;

  localparam logic REG_INITIAL_TEMPO      = 1'b0;
  localparam logic REG_INITIAL_LENGTH_DEN = 1'b1;

  localparam logic [17:0] MS_PER_WHOLE   = 18'd240000;
  localparam logic [6:0]  OCTAVE_STEP    = 7'd12;
  localparam logic [4:0]  LEN_DEN_SHORT  = 5'd16;
  localparam logic [4:0]  LEN_DEN_LONG   = 5'd8;
  localparam logic [6:0]  RESET_LEN_DEN  = 7'd8;
  localparam logic [15:0] RESET_TEMPO    = 16'd120;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_H   = 8'h48;
  localparam logic [7:0] CH_UP_J   = 8'h4A;
  localparam logic [7:0] CH_UP_K   = 8'h4B;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_UP_M   = 8'h4D;
  localparam logic [7:0] CH_UP_N   = 8'h4E;
  localparam logic [7:0] CH_UP_P   = 8'h50;
  localparam logic [7:0] CH_UP_Q   = 8'h51;
  localparam logic [7:0] CH_UP_R   = 8'h52;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  function automatic logic sym_is(sym_t s, logic [7:0] c);
    return !s.eot && (s.ch == c);
  endfunction

  function automatic logic is_skip_header(sym_t s);
    return !s.eot && (((s.ch >= CH_UP_H) && (s.ch <= CH_UP_J)) ||
                      ((s.ch >= CH_UP_N) && (s.ch <= CH_UP_P)) ||
                      ((s.ch >= CH_UP_R) && (s.ch <= CH_UP_Z)) ||
                      (s.ch == CH_PCT));
  endfunction

  function automatic logic is_note(logic [7:0] c);
    case (c)
      8'h7A, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
      8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [6:0] letter_pitch(logic [7:0] c);
    case (c)
      8'h43: return 7'd13;
      8'h44: return 7'd15;
      8'h45: return 7'd17;
      8'h46: return 7'd18;
      8'h47: return 7'd20;
      8'h41: return 7'd22;
      8'h42: return 7'd24;
      8'h63: return 7'd25;
      8'h64: return 7'd27;
      8'h65: return 7'd29;
      8'h66: return 7'd30;
      8'h67: return 7'd32;
      8'h61: return 7'd34;
      8'h62: return 7'd36;
      default: return 7'd0;
    endcase
  endfunction

endpackage

FILE: sv/abc_note_stream_parser.sv
// Top level of the ABC note stream parser: byte queue, parser engine and divider.
// Input channel: one text byte per request (text_byte, end_of_text) on in_valid/in_stall.
// end_of_text finishes any pending note or header; its byte is ignored.
// Output channel: one request per note or rest (note_pitch, note_duration_ms,
// duration_clipped) on out_valid/out_stall, held in a register until taken.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// Index 0 loads the tempo, index 1 loads the default length denominator.
// A byte passes a four-entry queue before the engine parses it.
// An M, L or Q header ends in two runs of the shared divider, unless its length
// denominator or tempo is zero; a slash divisor on a note costs one run.
// The divider retires one quotient bit per cycle, and the engine parses no byte while it runs.
// Reset empties the queue, clears out_valid and restores tempo 120
// and default length 1/8 with a default duration of 0 ms.
// While the receiver stalls, a finished note waits in the output register; the
// engine keeps parsing until it has another note to emit, and the queue then fills
// and raises in_stall.
module abc_note_stream_parser #(
  parameter int NUMBER_WIDTH   = 16,
  parameter int DURATION_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                text_byte,
  input  logic                      end_of_text,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [6:0]         note_pitch,
  output logic [DURATION_WIDTH-1:0] note_duration_ms,
  output logic                      duration_clipped,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [15:0]               cfg_data
);
  import abcnsp_pkg::*;
  `include "abc_note_stream_parser_defines.svh"

  localparam int DVW = (NUMBER_WIDTH > 16) ? NUMBER_WIDTH : 16;
  localparam int QW  = (NUMBER_WIDTH + 18 > 32) ? NUMBER_WIDTH + 18 : 32;

  logic           q_valid;
  sym_t           q_sym;
  logic           pop;
  logic           div_start;
  logic [QW-1:0]  div_dividend;
  logic [DVW-1:0] div_divisor;
  logic           div_busy;
  logic           div_done;
  logic [QW-1:0]  div_quo;

  assign cfg_ready = 1'b1;

  abcnsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (text_byte),
    .in_eot   (end_of_text),
    .in_stall (in_stall),
    .q_valid  (q_valid),
    .q_sym    (q_sym),
    .pop      (pop)
  );

  abcnsp_div #(
    .QW  (QW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  abcnsp_engine #(
    .NUMBER_WIDTH   (NUMBER_WIDTH),
    .DURATION_WIDTH (DURATION_WIDTH),
    .DVW            (DVW),
    .QW             (QW)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_sym            (q_sym),
    .pop              (pop),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .div_start        (div_start),
    .div_dividend     (div_dividend),
    .div_divisor      (div_divisor),
    .div_done         (div_done),
    .div_quo          (div_quo),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .note_pitch       (note_pitch),
    .note_duration_ms (note_duration_ms),
    .duration_clipped (duration_clipped)
  );

  `ABCNSP_ASSERT_SAME(a_pop_has_data, pop, q_valid, "engine popped an empty queue")
  `ABCNSP_ASSERT_SAME(a_start_idle, div_start, !div_busy, "divider started while busy")
  `ABCNSP_ASSERT_NEXT(a_start_busy, div_start, div_busy, "divider did not start")

endmodule

FILE: sv/abcnsp_queue.sv
// Front end: accepts text bytes, tags digits and end marks, and queues them.
module abcnsp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               in_eot,
  output logic               in_stall,
  output logic               q_valid,
  output abcnsp_pkg::sym_t   q_sym,
  input  logic               pop
);
  import abcnsp_pkg::*;

  sym_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       push;
  sym_t       entry;

  always_comb begin
    entry.eot   = in_eot;
    entry.digit = !in_eot && (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    entry.ch    = in_byte;
  end

  assign in_stall = (count == 3'd4);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 3'd0);
  assign q_sym    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule

FILE: sv/abcnsp_div.sv
// Restoring divider that produces one quotient bit per cycle.
module abcnsp_div #(
  parameter int QW  = 34,
  parameter int DVW = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [QW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [QW-1:0]  quotient
);
  localparam int CW = $clog2(QW);

  logic [CW-1:0]  cnt;
  logic [DVW-1:0] rem;
  logic [DVW-1:0] dvs;
  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic           ge;

  assign trial = {rem, quotient[QW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[QW-2:0], ge};
      rem      <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/abcnsp_engine.sv
// Back end: ABC parser state machine with duration arithmetic and output register.
module abcnsp_engine #(
  parameter int NUMBER_WIDTH   = 16,
  parameter int DURATION_WIDTH = 16,
  parameter int DVW            = 16,
  parameter int QW             = 34
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  abcnsp_pkg::sym_t          q_sym,
  output logic                      pop,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [15:0]               cfg_data,
  output logic                      div_start,
  output logic [QW-1:0]             div_dividend,
  output logic [DVW-1:0]            div_divisor,
  input  logic                      div_done,
  input  logic [QW-1:0]             div_quo,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [6:0]         note_pitch,
  output logic [DURATION_WIDTH-1:0] note_duration_ms,
  output logic                      duration_clipped
);
  import abcnsp_pkg::*;

  localparam int N  = NUMBER_WIDTH;
  localparam int D  = DURATION_WIDTH;
  localparam int AW = N + 4;
  localparam int MW = N + 2;
  localparam int PW = 32 + N;

  mode_t       mode, mode_next;
  seq_t        seq, seq_next;
  hkind_t      hkind, hkind_next;
  logic        in_chord, in_chord_next;
  logic        sharp, sharp_next;
  logic        flat, flat_next;
  logic [6:0]  pitch, pitch_next;
  logic [N-1:0] acc, acc_next;
  logic [N-1:0] first, first_next;
  logic [N-1:0] len_num, len_num_next;
  logic [DVW-1:0] len_den, len_den_next;
  logic [DVW-1:0] tempo, tempo_next;
  logic [D-1:0] dflt, dflt_next;
  logic [31:0] rd, rd_next;
  logic        pop_after, pop_after_next;
  logic        out_valid_next;
  logic [6:0]  out_pitch_next;
  logic [D-1:0] out_dur_next;
  logic        out_clip_next;

  logic [AW-1:0] dig_sum;
  logic [N-1:0]  acc_dig;
  logic          note_ok;
  logic [6:0]    note_val;
  logic [PW-1:0] prod;
  logic [31:0]   rd_mul;
  logic [32:0]   dot_sum;
  logic [31:0]   rd_dot;
  logic          rd_clip;
  logic [D-1:0]  rd_sat;
  logic [D-1:0]  q_sat;
  logic          consume;
  logic          fin;
  logic [N-1:0]  fin_a;
  logic [N-1:0]  fin_b;
  logic          out_free;

  assign dig_sum  = (AW'(acc) << 3) + (AW'(acc) << 1) + AW'(q_sym.ch[3:0]);
  assign acc_dig  = (|dig_sum[AW-1:N]) ? '1 : dig_sum[N-1:0];
  assign note_ok  = !q_sym.eot && is_note(q_sym.ch);
  assign note_val = letter_pitch(q_sym.ch) + {6'd0, sharp} - {6'd0, flat};
  assign prod     = PW'(rd) * PW'(acc);
  assign rd_mul   = ((prod >> 32) != '0) ? '1 : prod[31:0];
  assign dot_sum  = {1'b0, rd} + {2'b0, rd[31:1]};
  assign rd_dot   = dot_sum[32] ? '1 : dot_sum[31:0];
  assign rd_clip  = ((rd >> D) != '0);
  assign rd_sat   = rd_clip ? '1 : rd[D-1:0];
  assign q_sat    = ((div_quo >> D) != '0) ? '1 : div_quo[D-1:0];
  assign out_free = !(out_valid && out_stall);

  always_comb begin
    mode_next      = mode;
    seq_next       = seq;
    hkind_next     = hkind;
    in_chord_next  = in_chord;
    sharp_next     = sharp;
    flat_next      = flat;
    pitch_next     = pitch;
    acc_next       = acc;
    first_next     = first;
    len_num_next   = len_num;
    len_den_next   = len_den;
    tempo_next     = tempo;
    dflt_next      = dflt;
    rd_next        = rd;
    pop_after_next = pop_after;
    out_valid_next = out_valid && out_stall;
    out_pitch_next = note_pitch;
    out_dur_next   = note_duration_ms;
    out_clip_next  = duration_clipped;
    pop            = 1'b0;
    div_start      = 1'b0;
    div_dividend   = QW'(len_num) * QW'(MS_PER_WHOLE);
    div_divisor    = len_den;
    consume        = 1'b0;
    fin            = 1'b0;
    fin_a          = acc;
    fin_b          = N'(1);

    case (seq)
      SQ_PARSE: begin
        if (q_valid) begin
          case (mode)
            P_IDLE: begin
              consume = 1'b1;
              if (sym_is(q_sym, CH_QUOTE)) begin
                mode_next = P_QUOTE;
              end else if (sym_is(q_sym, CH_PLUS)) begin
                mode_next = P_PLUS;
              end else if (is_skip_header(q_sym)) begin
                mode_next = P_LINE;
              end else if (sym_is(q_sym, CH_UP_K)) begin
                mode_next = P_KEY;
              end else if (sym_is(q_sym, CH_UP_M)) begin
                hkind_next = HK_M;
                mode_next  = P_HPRE;
              end else if (sym_is(q_sym, CH_UP_L)) begin
                hkind_next = HK_L;
                mode_next  = P_HPRE;
              end else if (sym_is(q_sym, CH_UP_Q)) begin
                hkind_next = HK_Q;
                mode_next  = P_HPRE;
              end else if (sym_is(q_sym, CH_LBRK)) begin
                in_chord_next = 1'b1;
              end else if (sym_is(q_sym, CH_BAR) || sym_is(q_sym, CH_RBRK)) begin
                in_chord_next = 1'b0;
              end else if (sym_is(q_sym, CH_CARET)) begin
                sharp_next = 1'b1;
                mode_next  = P_SHARP;
              end else if (sym_is(q_sym, CH_UNDER)) begin
                flat_next = 1'b1;
                mode_next = P_FLAT;
              end else if (!sym_is(q_sym, CH_SPACE)) begin
                if (note_ok) begin
                  pitch_next = note_val;
                  mode_next  = P_OCT_UP;
                end
                sharp_next = 1'b0;
                flat_next  = 1'b0;
              end
            end
            P_QUOTE: begin
              consume = 1'b1;
              if (sym_is(q_sym, CH_QUOTE)) begin
                mode_next = P_IDLE;
              end
            end
            P_PLUS: begin
              consume = 1'b1;
              if (sym_is(q_sym, CH_PLUS)) begin
                mode_next = P_IDLE;
              end
            end
            P_LINE: begin
              consume = 1'b1;
              if (sym_is(q_sym, CH_NL)) begin
                mode_next = P_IDLE;
              end
            end
            P_KEY: begin
              consume = !sym_is(q_sym, CH_RBRK);
              if (sym_is(q_sym, CH_NL) || sym_is(q_sym, CH_RBRK)) begin
                mode_next = P_IDLE;
              end
            end
            P_CHORD: begin
              consume = 1'b1;
              if (sym_is(q_sym, CH_RBRK)) begin
                in_chord_next = 1'b0;
                mode_next     = P_IDLE;
              end
            end
            P_HPRE: begin
              if (sym_is(q_sym, CH_COLON) || sym_is(q_sym, CH_SPACE)) begin
                consume = 1'b1;
              end else begin
                acc_next  = '0;
                mode_next = P_HNUM;
              end
            end
            P_HNUM: begin
              if (q_sym.digit) begin
                acc_next = acc_dig;
                consume  = 1'b1;
              end else begin
                first_next = acc;
                acc_next   = '0;
                if (sym_is(q_sym, CH_SLASH)) begin
                  mode_next = P_HDEN;
                  consume   = 1'b1;
                end else begin
                  fin   = 1'b1;
                  fin_a = acc;
                end
              end
            end
            P_HDEN: begin
              if (q_sym.digit) begin
                acc_next = acc_dig;
                consume  = 1'b1;
              end else if (hkind == HK_Q) begin
                mode_next = P_QEQ;
              end else begin
                fin   = 1'b1;
                fin_a = first;
                fin_b = acc;
              end
            end
            P_QEQ: begin
              consume = 1'b1;
              if (sym_is(q_sym, CH_EQ)) begin
                mode_next = P_QSP;
              end
            end
            P_QSP: begin
              if (sym_is(q_sym, CH_SPACE)) begin
                consume = 1'b1;
              end else begin
                acc_next  = '0;
                mode_next = P_QBPM;
              end
            end
            P_QBPM: begin
              if (q_sym.digit) begin
                acc_next = acc_dig;
                consume  = 1'b1;
              end else begin
                fin   = 1'b1;
                fin_a = acc;
              end
            end
            P_SHARP: begin
              consume = 1'b1;
              if (sym_is(q_sym, CH_UNDER)) begin
                flat_next = 1'b1;
                mode_next = P_FLAT;
              end else if (!sym_is(q_sym, CH_CARET)) begin
                if (note_ok) begin
                  pitch_next = note_val;
                  mode_next  = P_OCT_UP;
                end else begin
                  mode_next = P_IDLE;
                end
                sharp_next = 1'b0;
                flat_next  = 1'b0;
              end
            end
            P_FLAT: begin
              consume = 1'b1;
              if (!sym_is(q_sym, CH_UNDER)) begin
                if (note_ok) begin
                  pitch_next = note_val;
                  mode_next  = P_OCT_UP;
                end else begin
                  mode_next = P_IDLE;
                end
                sharp_next = 1'b0;
                flat_next  = 1'b0;
              end
            end
            P_OCT_UP: begin
              mode_next = P_OCT_DOWN;
              if (sym_is(q_sym, CH_APOS)) begin
                pitch_next = pitch + OCTAVE_STEP;
                consume    = 1'b1;
              end
            end
            P_OCT_DOWN: begin
              rd_next   = 32'(dflt);
              acc_next  = '0;
              mode_next = P_DMUL;
              if (sym_is(q_sym, CH_COMMA)) begin
                pitch_next = pitch - OCTAVE_STEP;
                consume    = 1'b1;
              end
            end
            P_DMUL: begin
              if (q_sym.digit) begin
                acc_next = acc_dig;
                consume  = 1'b1;
              end else begin
                if (acc != '0) begin
                  rd_next = rd_mul;
                end
                acc_next = '0;
                if (sym_is(q_sym, CH_SLASH)) begin
                  mode_next = P_DDIV;
                  consume   = 1'b1;
                end else begin
                  mode_next = P_DOTS;
                end
              end
            end
            P_DDIV: begin
              if (q_sym.digit) begin
                acc_next = acc_dig;
                consume  = 1'b1;
              end else begin
                div_start      = 1'b1;
                div_dividend   = QW'(rd);
                div_divisor    = (acc != '0) ? DVW'(acc) : DVW'(2);
                acc_next       = '0;
                pop_after_next = sym_is(q_sym, CH_SLASH);
                mode_next      = sym_is(q_sym, CH_SLASH) ? P_DDIV : P_DOTS;
                seq_next       = SQ_RDIV;
              end
            end
            P_DOTS: begin
              if (sym_is(q_sym, CH_GT)) begin
                rd_next = rd_dot;
                consume = 1'b1;
              end else if (out_free) begin
                out_valid_next = 1'b1;
                out_pitch_next = pitch;
                out_dur_next   = rd_sat;
                out_clip_next  = rd_clip;
                mode_next      = in_chord ? P_CHORD : P_IDLE;
              end
            end
            default: begin
              consume   = 1'b1;
              mode_next = P_IDLE;
            end
          endcase

          if (fin) begin
            mode_next = P_IDLE;
            seq_next  = SQ_HMUL;
            case (hkind)
              HK_M: begin
                len_num_next = N'(1);
                len_den_next = ((MW'(fin_a) << 2) < ((MW'(fin_b) << 1) + MW'(fin_b))) ?
                               DVW'(LEN_DEN_SHORT) : DVW'(LEN_DEN_LONG);
              end
              HK_L: begin
                len_num_next = fin_a;
                len_den_next = DVW'(fin_b);
              end
              default: begin
                tempo_next = DVW'(fin_a);
              end
            endcase
          end

          if (consume) begin
            pop = 1'b1;
            if (q_sym.eot) begin
              mode_next     = P_IDLE;
              in_chord_next = 1'b0;
              sharp_next    = 1'b0;
              flat_next     = 1'b0;
              acc_next      = '0;
            end
          end
        end
      end
      SQ_HMUL: begin
        if ((len_den == '0) || (tempo == '0)) begin
          dflt_next = '1;
          seq_next  = SQ_PARSE;
        end else begin
          div_start = 1'b1;
          seq_next  = SQ_HDIV;
        end
      end
      SQ_HDIV: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = div_quo;
          div_divisor  = tempo;
          seq_next     = SQ_TDIV;
        end
      end
      SQ_TDIV: begin
        if (div_done) begin
          dflt_next = q_sat;
          seq_next  = SQ_PARSE;
        end
      end
      SQ_RDIV: begin
        if (div_done) begin
          rd_next  = div_quo[31:0];
          pop      = pop_after;
          seq_next = SQ_PARSE;
        end
      end
      default: begin
        seq_next = SQ_PARSE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_INITIAL_TEMPO: begin
          tempo_next = DVW'(cfg_data);
        end
        REG_INITIAL_LENGTH_DEN: begin
          len_num_next = N'(1);
          len_den_next = DVW'(cfg_data[6:0]);
        end
        default: begin
          tempo_next = tempo;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= P_IDLE;
      seq       <= SQ_PARSE;
      hkind     <= HK_M;
      in_chord  <= 1'b0;
      sharp     <= 1'b0;
      flat      <= 1'b0;
      pitch     <= '0;
      acc       <= '0;
      first     <= '0;
      len_num   <= N'(1);
      len_den   <= DVW'(RESET_LEN_DEN);
      tempo     <= DVW'(RESET_TEMPO);
      dflt      <= '0;
      rd        <= '0;
      pop_after <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mode      <= mode_next;
      seq       <= seq_next;
      hkind     <= hkind_next;
      in_chord  <= in_chord_next;
      sharp     <= sharp_next;
      flat      <= flat_next;
      pitch     <= pitch_next;
      acc       <= acc_next;
      first     <= first_next;
      len_num   <= len_num_next;
      len_den   <= len_den_next;
      tempo     <= tempo_next;
      dflt      <= dflt_next;
      rd        <= rd_next;
      pop_after <= pop_after_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    note_pitch       <= out_pitch_next;
    note_duration_ms <= out_dur_next;
    duration_clipped <= out_clip_next;
  end

endmodule

FILE: sim/abc_note_stream_parser_tb.sv
// Self-checking testbench for the ABC note stream parser: text in, notes checked against a predictor.
`timescale 1ns / 1ps

module abc_note_stream_parser_tb;
  import abcnsp_pkg::*;

  localparam int END_SYM = 256;
  localparam logic [63:0] NUM_MAX = 64'hFFFF;
  localparam logic [63:0] DUR_MAX = 64'hFFFF;
  localparam logic [63:0] RUN_MAX = 64'hFFFF_FFFF;
  localparam string LETTERS = "zCDEFGABcdefgab";

  typedef struct {
    logic signed [6:0] pitch;
    logic [15:0]       dur;
    logic              clipped;
  } note_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] text_byte = '0;
  logic end_of_text = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [6:0] note_pitch;
  logic [15:0] note_duration_ms;
  logic duration_clipped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_INITIAL_TEMPO;
  logic [15:0] cfg_data = '0;

  note_t expected_notes[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int notes_seen = 0;
  int cfg_writes = 0;
  bit quiet = 1'b0;
  int stall_cnt = 0;

  // Predictor state.
  mode_t mode;
  hkind_t hkind;
  bit chord, sharp, flat;
  int pitch;
  logic [63:0] acc, first_num, len_num, len_den, tempo, def_dur, run_dur;
  bit have_note;
  note_t new_note;

  abc_note_stream_parser uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .text_byte(text_byte), .end_of_text(end_of_text), .out_valid(out_valid),
    .out_stall(out_stall), .note_pitch(note_pitch), .note_duration_ms(note_duration_ms),
    .duration_clipped(duration_clipped), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit is_dig(int c);
    return c >= "0" && c <= "9";
  endfunction

  function void take_digit(int c);
    logic [63:0] v;
    v = acc * 10 + (c - "0");
    acc = (v > NUM_MAX) ? NUM_MAX : v;
  endfunction

  function automatic logic [63:0] cap_run(logic [63:0] v);
    return (v > RUN_MAX) ? RUN_MAX : v;
  endfunction

  function void recompute();
    logic [63:0] t;
    if (len_den == 0 || tempo == 0) begin
      def_dur = DUR_MAX;
    end else begin
      t = (64'd240000 * len_num) / len_den;
      t = t / tempo;
      def_dur = (t > DUR_MAX) ? DUR_MAX : t;
    end
  endfunction

  function void finish_header(logic [63:0] a, logic [63:0] b);
    case (hkind)
      HK_M: begin
        len_num = 1;
        len_den = (4 * a < 3 * b) ? 16 : 8;
      end
      HK_L: begin
        len_num = a;
        len_den = b;
      end
      default: tempo = a;
    endcase
    recompute();
    mode = P_IDLE;
  endfunction

  function automatic int pitch_of(int c);
    case (c)
      "z": return 0;
      "C": return 13; "D": return 15; "E": return 17; "F": return 18;
      "G": return 20; "A": return 22; "B": return 24; "c": return 25;
      "d": return 27; "e": return 29; "f": return 30; "g": return 32;
      "a": return 34; "b": return 36;
      default: return -1;
    endcase
  endfunction

  function void start_note(int c);
    int v;
    v = pitch_of(c);
    if (v >= 0) begin
      pitch = v + (sharp ? 1 : 0) - (flat ? 1 : 0);
      mode = P_OCT_UP;
    end else begin
      mode = P_IDLE;
    end
    sharp = 0;
    flat = 0;
  endfunction

  function automatic bit skipped_line(int c);
    return (c >= "H" && c <= "J") || (c >= "N" && c <= "P") ||
           (c >= "R" && c <= "Z") || c == "%";
  endfunction

  // Returns 1 when the symbol has to be parsed again in the new mode.
  function bit parse_symbol(int c);
    case (mode)
      P_IDLE: begin
        if (c == "\"") mode = P_QUOTE;
        else if (c == "+") mode = P_PLUS;
        else if (skipped_line(c)) mode = P_LINE;
        else if (c == "K") mode = P_KEY;
        else if (c == "M" || c == "L" || c == "Q") begin
          hkind = (c == "M") ? HK_M : (c == "L") ? HK_L : HK_Q;
          mode = P_HPRE;
        end
        else if (c == "[") chord = 1;
        else if (c == "|" || c == "]") chord = 0;
        else if (c == "^") begin sharp = 1; mode = P_SHARP; end
        else if (c == "_") begin flat = 1; mode = P_FLAT; end
        else if (c != " ") start_note(c);
        return 0;
      end
      P_QUOTE: begin if (c == "\"") mode = P_IDLE; return 0; end
      P_PLUS: begin if (c == "+") mode = P_IDLE; return 0; end
      P_LINE: begin if (c == 10) mode = P_IDLE; return 0; end
      P_KEY: begin
        if (c == 10) begin mode = P_IDLE; return 0; end
        if (c == "]") begin mode = P_IDLE; return 1; end
        return 0;
      end
      P_CHORD: begin
        if (c == "]") begin chord = 0; mode = P_IDLE; end
        return 0;
      end
      P_HPRE: begin
        if (c == ":" || c == " ") return 0;
        acc = 0;
        mode = P_HNUM;
        return 1;
      end
      P_HNUM: begin
        if (is_dig(c)) begin take_digit(c); return 0; end
        first_num = acc;
        acc = 0;
        if (c == "/") begin mode = P_HDEN; return 0; end
        finish_header(first_num, 1);
        return 1;
      end
      P_HDEN: begin
        if (is_dig(c)) begin take_digit(c); return 0; end
        if (hkind == HK_Q) begin mode = P_QEQ; return 1; end
        finish_header(first_num, acc);
        return 1;
      end
      P_QEQ: begin if (c == "=") mode = P_QSP; return 0; end
      P_QSP: begin
        if (c == " ") return 0;
        acc = 0;
        mode = P_QBPM;
        return 1;
      end
      P_QBPM: begin
        if (is_dig(c)) begin take_digit(c); return 0; end
        finish_header(acc, 1);
        return 1;
      end
      P_SHARP: begin
        if (c == "^") return 0;
        if (c == "_") begin flat = 1; mode = P_FLAT; return 0; end
        start_note(c);
        return 0;
      end
      P_FLAT: begin
        if (c != "_") start_note(c);
        return 0;
      end
      P_OCT_UP: begin
        mode = P_OCT_DOWN;
        if (c == "'") begin pitch += 12; return 0; end
        return 1;
      end
      P_OCT_DOWN: begin
        run_dur = def_dur;
        acc = 0;
        mode = P_DMUL;
        if (c == ",") begin pitch -= 12; return 0; end
        return 1;
      end
      P_DMUL: begin
        if (is_dig(c)) begin take_digit(c); return 0; end
        if (acc > 0) run_dur = cap_run(run_dur * acc);
        acc = 0;
        if (c == "/") begin mode = P_DDIV; return 0; end
        mode = P_DOTS;
        return 1;
      end
      P_DDIV: begin
        if (is_dig(c)) begin take_digit(c); return 0; end
        run_dur = run_dur / ((acc > 0) ? acc : 64'd2);
        acc = 0;
        if (c == "/") return 0;
        mode = P_DOTS;
        return 1;
      end
      P_DOTS: begin
        if (c == ">") begin
          run_dur = cap_run(run_dur + run_dur / 2);
          return 0;
        end
        have_note = 1;
        new_note.pitch = pitch[6:0];
        new_note.dur = (run_dur > DUR_MAX) ? DUR_MAX[15:0] : run_dur[15:0];
        new_note.clipped = run_dur > DUR_MAX;
        mode = chord ? P_CHORD : P_IDLE;
        return 1;
      end
      default: begin
        mode = P_IDLE;
        return 0;
      end
    endcase
  endfunction

  function void predict_notes(logic [7:0] b, logic e);
    int c;
    c = e ? END_SYM : int'(b);
    have_note = 0;
    for (int i = 0; i < 12; i++)
      if (!parse_symbol(c)) break;
    if (e) begin
      mode = P_IDLE;
      chord = 0;
      sharp = 0;
      flat = 0;
      acc = 0;
    end
    if (have_note) expected_notes.push_back(new_note);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("note %0d: %s is %0d, expected %0d", notes_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    note_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_notes.size() == 0) begin
        $display("note %0d: unexpected request, pitch %0d duration %0d", notes_seen,
                 note_pitch, note_duration_ms);
        mismatches++;
      end else begin
        want = expected_notes.pop_front();
        if (note_pitch !== want.pitch)
          report_mismatch("pitch", note_pitch, want.pitch);
        if (note_duration_ms !== want.dur)
          report_mismatch("duration", note_duration_ms, want.dur);
        if (duration_clipped !== want.clipped)
          report_mismatch("clip flag", duration_clipped, want.clipped);
      end
      notes_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_cnt <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(logic [7:0] b, logic e = 1'b0);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= e;
    do @(posedge clk); while (in_stall);
    predict_notes(b, e);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    send_byte($urandom_range(0, 255), 1'b1);
    in_valid <= 1'b0;
    while (expected_notes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] bpm, logic [6:0] den);
    cfg_valid <= 1'b1;
    cfg_index <= REG_INITIAL_TEMPO;
    cfg_data <= bpm;
    do @(posedge clk); while (!cfg_ready);
    tempo = bpm;
    cfg_index <= REG_INITIAL_LENGTH_DEN;
    cfg_data <= {9'd0, den};
    do @(posedge clk); while (!cfg_ready);
    len_num = 1;
    len_den = den;
    cfg_valid <= 1'b0;
    cfg_writes += 2;
    @(posedge clk);
  endtask

  function automatic string rand_number();
    case ($urandom_range(0, 9))
      0: return "";
      1: return $sformatf("%0d", $urandom_range(0, 999999));
      default: return $sformatf("%0d", $urandom_range(1, 9));
    endcase
  endfunction

  function automatic string rand_note();
    string s;
    s = "";
    case ($urandom_range(0, 7))
      0: s = "^";
      1: s = "_";
      2: s = "^_";
      3: s = "__";
      default: s = "";
    endcase
    s = {s, string'(LETTERS[$urandom_range(0, 14)])};
    if ($urandom_range(0, 3) == 0) s = {s, "'"};
    if ($urandom_range(0, 3) == 0) s = {s, ","};
    if ($urandom_range(0, 2) == 0) s = {s, rand_number()};
    repeat ($urandom_range(0, 2)) s = {s, "/", rand_number()};
    repeat ($urandom_range(0, 2)) s = {s, ">"};
    return s;
  endfunction

  function automatic string rand_header();
    case ($urandom_range(0, 3))
      0: return $sformatf("M:%0d/%0d\n", $urandom_range(1, 12), $urandom_range(1, 8));
      1: return $sformatf("L: %0d/%0d\n", $urandom_range(0, 3), $urandom_range(0, 64));
      2: return $sformatf("Q:%0d\n", $urandom_range(0, 400));
      default: return $sformatf("Q:1/4= %0d ", $urandom_range(20, 300));
    endcase
  endfunction

  function automatic string rand_fragment();
    case ($urandom_range(0, 19))
      0, 1: return rand_header();
      2: return "\"Am7 x\"";
      3: return "+trill+";
      4: return "T:Title line\n";
      5: return "K:G\n";
      6: return "[K:D]";
      7: return {"[", rand_note(), rand_note(), "]"};
      8: return "|";
      9: return " ";
      10: return {string'(8'($urandom_range(0, 255)))};
      default: return rand_note();
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_text("CDz|");
    drain();
  endtask

  task automatic test_directed_notes();
    configure(16'd1, 7'd1);
    send_text("L:1/1\nC99999>>>D/E//F/0G3/4^^c'__b,_^A");
    send_byte("d");
    send_byte(8'hFF);
    send_text("Q:0\nC L:1/0\nD M:2/4\nz");
    drain();
    configure(16'd65535, 7'd64);
    send_text("M:\nC Q:3/8=\n90 ^x\"q\"+x+[CEG]d|K:C]e% c\nf");
    drain();
  endtask

  task automatic test_random_text(int n_bytes, logic [15:0] bpm, logic [6:0] den);
    int stop;
    configure(bpm, den);
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) send_text(rand_fragment());
    drain();
  endtask

  initial begin
    mode = P_IDLE;
    hkind = HK_M;
    {chord, sharp, flat} = '0;
    pitch = 0;
    acc = 0;
    first_num = 0;
    len_num = 1;
    len_den = RESET_LEN_DEN;
    tempo = RESET_TEMPO;
    def_dur = 0;
    run_dur = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_notes();
    test_random_text(200, 16'd120, 7'd8);
    test_random_text(200, $urandom_range(1, 65535), $urandom_range(1, 64));
    test_random_text(200, 16'd1, 7'd64);
    quiet = 1'b1;
    test_random_text(200, 16'd65535, 7'd1);
    $display("Sent %0d text bytes and checked %0d notes across %0d register writes.",
             bytes_sent, notes_seen, cfg_writes);
    $display("Covered headers, chords, skipped text, accidentals, octaves and durations.");
    if (mismatches == 0 && expected_notes.size() == 0)
      $display("abc_note_stream_parser: match");
    else
      $display("abc_note_stream_parser: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d notes outstanding.", expected_notes.size());
    $display("abc_note_stream_parser: mismatch");
    $finish;
  end

endmodule

FILE: abc_note_stream_parser.f
+incdir+sv
sv/abcnsp_pkg.sv
sv/abcnsp_queue.sv
sv/abcnsp_div.sv
sv/abcnsp_engine.sv
sv/abc_note_stream_parser.sv
sim/abc_note_stream_parser_tb.sv
